// ----- src/oaht_pkg.sv -----
// Shared types, codes and sizing constants of the open-addressing hash table.
// No dependencies; imported by every module of the block.
`default_nettype none
package oaht_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_PROBE_LIMIT = 100;

    // Field widths
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int SIZE_W    = 6;
    localparam int METH_W    = 2;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Remainder unit: dividend bits retired per cycle
    localparam int DIGIT_BITS = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_STORED    = 2'd0;
    localparam logic [ST_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // Probe methods; the unused code probes linearly
    localparam logic [METH_W-1:0] METH_LINEAR = 2'd0;
    localparam logic [METH_W-1:0] METH_QUAD   = 2'd1;
    localparam logic [METH_W-1:0] METH_KEYMUL = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_METHOD = 1'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

endpackage
`default_nettype wire

// ----- src/oaht_urem.sv -----
// Multi-cycle remainder unit: key mod table size, DIGIT_BITS dividend bits a cycle.
// Depends on oaht_pkg.
`default_nettype none
module oaht_urem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [oaht_pkg::KEY_W-1:0]  i_dividend,
    input  wire logic [oaht_pkg::SIZE_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [oaht_pkg::SIZE_W-1:0]      o_rem
);
    import oaht_pkg::*;

    localparam int DIV_W = ((KEY_W + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
    localparam int STEPS = DIV_W / DIGIT_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_sh;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] n_rem;

    // Restoring steps: shift in one bit, subtract the divisor if it fits
    always_comb begin
        logic [SIZE_W:0] t;
        t     = '0;
        n_rem = r_rem;
        for (int b = 0; b < DIGIT_BITS; b++) begin
            t = {n_rem, r_sh[DIV_W-1-b]};
            if (t >= {1'b0, i_divisor}) begin
                t = t - {1'b0, i_divisor};
            end
            n_rem = t[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= DIV_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << DIGIT_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- src/open_addressing_hash_table.sv -----
// Open-addressing hash table. Each word is hashed (key mod size in the remainder unit, then the
// first slot is loaded), then probed slot by slot, each probe a read and then a check, until
// the result word is registered.
// Throughput: one word at a time; the next word is taken the cycle after the result is
// registered; a result still waiting on the stream holds the search.
// Reset: synchronous, active low; a clearing pass then empties the table slot by slot,
// taking no word meanwhile (configuration writes are taken).
`default_nettype none
module open_addressing_hash_table #(
    parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
    parameter int PROBE_LIMIT = oaht_pkg::DEF_PROBE_LIMIT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [oaht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [oaht_pkg::CFG_W-1:0]     i_cfg_data,
    // request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata,  // key[30:0], value[62:31], pad
    input  wire logic                          s_axis_tuser,  // operation
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // found_value[31:0]
    output logic [oaht_pkg::ST_W-1:0]           m_axis_tuser   // status[1:0]
);
    import oaht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    // ---------------------------------------------------------------- config
    logic [SIZE_W-1:0] r_size_cfg;
    logic [METH_W-1:0] r_method;
    logic [SIZE_W-1:0] eff_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_cfg <= SIZE_RESET;
            r_method   <= METH_LINEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TABLE_SIZE:   r_size_cfg <= i_cfg_data[SIZE_W-1:0];
                REG_PROBE_METHOD: r_method   <= i_cfg_data[METH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Zero acts as one slot, anything past the memory as the whole memory
    always_comb begin
        if (r_size_cfg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (32'(r_size_cfg) > TABLE_DEPTH) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            eff_size = r_size_cfg;
        end
    end

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;

    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [SIZE_W-1:0] r_pos;      // slot of the current probe
    logic [SIZE_W-1:0] r_km;       // key mod size, step of key-multiple probing
    logic [SIZE_W-1:0] r_dq;       // (2i+1) mod size, step of quadratic probing
    logic [IW-1:0]     r_idx;      // probe number
    logic [AW-1:0]     r_clr;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [VAL_W-1:0]  r_value;

    // slot memory
    t_slot             r_mem [TABLE_DEPTH];
    t_slot             r_rd;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_slot             mem_wdata;

    // remainder unit
    logic              hash_start;
    logic              hash_done;
    logic [SIZE_W-1:0] hash_rem;

    // probe decisions
    logic              accept;
    logic              out_free;
    logic              hit_stop;     // probe ends the search on its own
    logic              last_probe;
    logic              finish;
    logic [ST_W-1:0]   n_status;
    logic [VAL_W-1:0]  n_value;
    logic [SIZE_W-1:0] n_pos;
    logic [SIZE_W-1:0] n_dq;

    oaht_urem u_urem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (hash_start),
        .i_dividend (s_axis_tdata[KEY_W-1:0]),
        .i_divisor  (eff_size),
        .o_done     (hash_done),
        .o_rem      (hash_rem)
    );

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Evaluate the slot just read
    always_comb begin
        hit_stop = 1'b0;
        n_status = (r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        n_value  = '0;
        if (r_op == OP_INSERT) begin
            if (!r_rd.used) begin
                hit_stop = 1'b1;
                n_status = ST_STORED;
            end
        end else begin
            if (!r_rd.used) begin
                hit_stop = 1'b1;
                n_status = ST_NOT_FOUND;
            end else if (r_rd.key == r_key) begin
                hit_stop = 1'b1;
                n_status = ST_FOUND;
                n_value  = r_rd.value;
            end
        end
    end

    assign last_probe = (r_idx == IW'(PROBE_LIMIT - 1));

    // Next probe slot, kept reduced mod size: each step adds no more than the size
    always_comb begin
        logic [SIZE_W:0] sum;
        logic [SIZE_W:0] dq2;
        case (r_method)
            METH_QUAD:   sum = {1'b0, r_pos} + {1'b0, r_dq};
            METH_KEYMUL: sum = {1'b0, r_pos} + {1'b0, r_km};
            default:     sum = {1'b0, r_pos} + (SIZE_W + 1)'(1);
        endcase
        if (sum >= {1'b0, eff_size}) begin
            sum = sum - {1'b0, eff_size};
        end
        n_pos = sum[SIZE_W-1:0];
        // a size of one needs the second correction
        dq2 = {1'b0, r_dq} + (SIZE_W + 1)'(2);
        if (dq2 >= {1'b0, eff_size}) begin
            dq2 = dq2 - {1'b0, eff_size};
        end
        if (dq2 >= {1'b0, eff_size}) begin
            dq2 = dq2 - {1'b0, eff_size};
        end
        n_dq = dq2[SIZE_W-1:0];
    end

    // ---------------------------------------------------------------- FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_HASH;
            S_HASH:  if (hash_done) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (hit_stop || last_probe) begin
                    if (out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // ---------------------------------------------------------------- FSM outputs
    always_comb begin
        s_axis_tready = 1'b0;
        hash_start    = 1'b0;
        finish        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_pos);
        mem_wdata     = '{used: 1'b1, key: r_key, value: r_val};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                hash_start    = s_axis_tvalid;
            end
            S_CHECK: begin
                // hold the search while the previous result still waits
                finish = (hit_stop || last_probe) && out_free;
                mem_we = finish && hit_stop && (r_op == OP_INSERT);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= s_axis_tuser;
            r_key <= s_axis_tdata[KEY_W-1:0];
            r_val <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (r_state == S_HASH && hash_done) begin
            // probe zero sits at key mod size; quadratic step starts at 1 mod size
            r_pos <= hash_rem;
            r_km  <= hash_rem;
            r_dq  <= (eff_size == SIZE_W'(1)) ? SIZE_W'(0) : SIZE_W'(1);
            r_idx <= '0;
        end else if (r_state == S_CHECK && !hit_stop && !last_probe) begin
            r_pos <= n_pos;
            r_dq  <= n_dq;
            r_idx <= r_idx + 1'b1;
        end
        if (finish) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[AW'(r_pos)];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_value;
    assign m_axis_tuser  = r_status;

    // ---------------------------------------------------------------- checks
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_pos < eff_size))
        else $error("probe slot outside the table size");

    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == S_HASH))
        else $error("remainder finished outside hashing");

    a_store_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && mem_we) |=> (m_axis_tvalid && m_axis_tuser == ST_STORED))
        else $error("slot written without a stored result");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !finish) |=> !s_axis_tready)
        else $error("word taken while a search is in flight");

endmodule
`default_nettype wire

// ----- bench/oaht_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the open-addressing hash table: keeps its own slot store, predicts
// one reply per accepted request and checks the result stream. Depends on oaht_pkg.
module oaht_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [oaht_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [oaht_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [63:0]                    s_axis_tdata,   // key[30:0], value[62:31], pad
    input  wire logic                           s_axis_tuser,   // operation
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [31:0]                    m_axis_tdata,   // found_value[31:0]
    input  wire logic [oaht_pkg::ST_W-1:0]      m_axis_tuser,   // status[1:0]
    output int                                  o_errors,
    output int                                  o_pending
);
    import oaht_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] found_value;
    } t_reply;

    logic             slot_used  [DEF_TABLE_DEPTH];
    logic [KEY_W-1:0] slot_key   [DEF_TABLE_DEPTH];
    logic [VAL_W-1:0] slot_value [DEF_TABLE_DEPTH];
    logic [SIZE_W-1:0] size_reg;
    logic [METH_W-1:0] method_reg;
    t_reply            expected_replies [$];
    int                error_count;

    // Walk the probe sequence; an insert claims the first free slot it meets.
    function automatic t_reply probe_table(logic op, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] value);
        longint unsigned modulus;
        longint unsigned pos;
        int              slot;
        t_reply          reply;
        modulus = (size_reg == 0) ? 1 :
                  (size_reg > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : size_reg;
        reply.status      = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        reply.found_value = '0;
        for (int i = 0; i < DEF_PROBE_LIMIT; i++) begin
            case (method_reg)
                METH_QUAD:   pos = longint'(key) + longint'(i) * longint'(i);
                METH_KEYMUL: pos = longint'(key) + longint'(key) * longint'(i);
                default:     pos = longint'(key) + longint'(i);
            endcase
            slot = int'(pos % modulus);
            if (op == OP_INSERT) begin
                if (!slot_used[slot]) begin
                    slot_used[slot]  = 1'b1;
                    slot_key[slot]   = key;
                    slot_value[slot] = value;
                    reply.status     = ST_STORED;
                    break;
                end
            end else if (!slot_used[slot]) begin
                reply.status = ST_NOT_FOUND;
                break;
            end else if (slot_key[slot] == key) begin
                reply.status      = ST_FOUND;
                reply.found_value = slot_value[slot];
                break;
            end
        end
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            size_reg    = SIZE_RESET;
            method_reg  = METH_LINEAR;
            error_count = 0;
            expected_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TABLE_SIZE:   size_reg   = i_cfg_data[SIZE_W-1:0];
                    REG_PROBE_METHOD: method_reg = i_cfg_data[METH_W-1:0];
                    default: ;
                endcase
            end
            // retire the oldest reply before queuing a new one
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected result word: status %0d, found_value %h",
                           m_axis_tuser, m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== want.found_value) begin
                        $error("found_value mismatch: expected %h, actual %h",
                               want.found_value, m_axis_tdata);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_replies.push_back(probe_table(s_axis_tuser,
                                                       s_axis_tdata[KEY_W-1:0],
                                                       s_axis_tdata[KEY_W+VAL_W-1:KEY_W]));
        end
        o_errors  = error_count;
        o_pending = expected_replies.size();
    end

endmodule

// ----- bench/tb_open_addressing_hash_table.sv -----
`timescale 1ns / 100ps
// Top of the hash table bench: clock, reset, request and result stream drivers.
// Depends on oaht_pkg, open_addressing_hash_table and oaht_checker.
module tb_open_addressing_hash_table;
    import oaht_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    // longest request: accept, hashing, a full probe run, each probe a read and a check
    localparam int DRAIN_CYCLES    = 250;
    localparam int HOLD_CYCLES     = 400;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int PRESSURE_PHASE  = 5;
    // method code with no meaning of its own; the block probes linearly on it
    localparam logic [METH_W-1:0] METH_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    // chance in a hundred of a gap before a request word / of a stall per cycle
    int unsigned gap_pct   [4] = '{0, 63, 0, 32};
    int unsigned stall_pct [4] = '{0, 0, 63, 32};

    // table size and probe method per random phase; the extremes and
    // the out-of-range codes are among them
    logic [SIZE_W-1:0] phase_size   [N_PHASES] = '{6'd4, 6'd8, 6'd16, 6'd32, 6'd1, 6'd0,
                                                   6'd63, 6'd20, 6'd32, 6'd2, 6'd33, 6'd32};
    logic [METH_W-1:0] phase_method [N_PHASES] = '{METH_LINEAR, METH_QUAD, METH_KEYMUL,
                                                   METH_LINEAR, METH_UNUSED, METH_QUAD,
                                                   METH_KEYMUL, METH_QUAD, METH_KEYMUL,
                                                   METH_LINEAR, METH_UNUSED, METH_QUAD};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = REG_TABLE_SIZE;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata  = '0;    // key[30:0], value[62:31], pad
    logic                 s_axis_tuser  = OP_INSERT; // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;          // found_value[31:0]
    logic [ST_W-1:0]      m_axis_tuser;          // status[1:0]

    int               errors;
    int               pending;
    int               cycle_count = 0;
    int               hold_request = 0;
    t_idle            idle_mode = IDLE_NONE;
    logic [KEY_W-1:0] stored_keys [$];

    open_addressing_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    oaht_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: give up on a hung block.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result side: stall at random per the idle mode; on request hold off
    // for a long stretch so the block backs up into its request port.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_request) begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct[idle_mode]);
            end
        end
    end

    // Offer one request word and hold it until taken. Enter and leave at a
    // falling edge without touching tvalid on the way out, so the next word
    // or the final drop is the only assignment in that step.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < gap_pct[idle_mode]) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (op == OP_INSERT)
            stored_keys.push_back(key);
    endtask

    // Drain every outstanding reply, then write both registers back to back.
    task automatic configure(input logic [SIZE_W-1:0] size, input logic [METH_W-1:0] method);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TABLE_SIZE;
        i_cfg_data  <= CFG_W'(size);
        @(negedge i_clk);
        i_cfg_index <= REG_PROBE_METHOD;
        i_cfg_data  <= CFG_W'(method);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic             op;
        logic [KEY_W-1:0] key;
        int unsigned      pick;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset settings: 32 slots, linear probing.
        send_request(OP_INSERT, '0, '1);
        send_request(OP_INSERT, '1, '0);
        send_request(OP_INSERT, '0, 32'h1234_5678);   // duplicate key takes the next slot
        send_request(OP_LOOKUP, '0, '1);              // first of the two duplicates
        send_request(OP_LOOKUP, '1, 32'h0F0F_0F0F);
        send_request(OP_LOOKUP, 31'd5, '0);           // stops at an empty slot

        // Size zero acts as one slot, the spare method code as linear.
        configure(6'd0, METH_UNUSED);
        send_request(OP_INSERT, 31'd7, 32'hDEAD_BEEF); // probe limit: full
        send_request(OP_LOOKUP, 31'd9, '0);            // probe limit: not found
        send_request(OP_LOOKUP, '0, '0);

        // Oversized table acts as the full depth.
        configure(6'd63, METH_QUAD);
        send_request(OP_INSERT, 31'd2, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 31'd2, 32'h5A5A_5A5A);
        send_request(OP_LOOKUP, 31'd2, '0);
        send_request(OP_LOOKUP, 31'd34, '0);

        // Key-multiple: a key that is a multiple of the size never leaves its slot.
        configure(6'd32, METH_KEYMUL);
        send_request(OP_INSERT, 31'd32, 32'h8000_0001);
        send_request(OP_LOOKUP, 31'd64, '0);
        send_request(OP_LOOKUP, '1, '0);
        send_request(OP_INSERT, 31'd1, 32'h7FFF_FFFE);
        send_request(OP_LOOKUP, 31'd1, '0);

        // Random phases: lookups mostly of keys already stored, inserts now and
        // then repeating a key; small keys crowd the table, wide ones toggle every bit.
        for (int p = 0; p < N_PHASES; p++) begin
            configure(phase_size[p], phase_method[p]);
            idle_mode = t_idle'(p % 4);
            if (p == PRESSURE_PHASE)
                hold_request++;
            repeat (ITEMS_PER_PHASE) begin
                op   = ($urandom_range(99) < 45) ? OP_INSERT : OP_LOOKUP;
                pick = $urandom_range(99);
                if (stored_keys.size() > 0 && pick < ((op == OP_LOOKUP) ? 60 : 25))
                    key = stored_keys[$urandom_range(stored_keys.size() - 1)];
                else if (pick < 80)
                    key = KEY_W'($urandom_range(127));
                else
                    key = KEY_W'($urandom);
                send_request(op, key, $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let the last replies come out, then watch for strays.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
src/oaht_pkg.sv
src/oaht_urem.sv
src/open_addressing_hash_table.sv
bench/oaht_checker.sv
bench/tb_open_addressing_hash_table.sv
